[rtl/core/phr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phr_pkg
// Shared sizes, opcodes, register indexes and control types of the
// horizontal resampler core.
// ----------------------------------------------------------------------------
package phr_pkg;

   localparam int MAX_TAPS  = 16;
   localparam int MAX_WIDTH = 4096;

   localparam int TAP_W     = $clog2(MAX_TAPS);        // tap number
   localparam int POS_W     = $clog2(MAX_WIDTH);       // sample / output index
   localparam int IDX_W     = POS_W + 1;               // left + tap, may pass the end
   localparam int CADDR_W   = POS_W + TAP_W;           // coefficient store address
   localparam int TCNT_W    = 5;                       // tap_count register
   localparam int IWID_W    = 13;                      // row length register
   localparam int SAMPLE_W  = 16;
   localparam int COEFF_W   = 16;
   localparam int PROD_W    = COEFF_W + SAMPLE_W + 1;
   localparam int ACC_W     = 40;
   localparam int FRAC_W    = 14;
   localparam int OPC_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   localparam logic [OPC_W-1:0] OP_SAMPLE  = 2'd0;
   localparam logic [OPC_W-1:0] OP_COEFF   = 2'd1;
   localparam logic [OPC_W-1:0] OP_LEFT    = 2'd2;
   localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LEN   = 1'd1;

   localparam logic [TCNT_W-1:0] TAP_COUNT_RST = 5'd1;
   localparam logic [IWID_W-1:0] ROW_LEN_RST   = 13'd4096;

   // controller -> datapath
   typedef struct packed {
      logic             accept;   // input transfer this cycle
      logic             start;    // compute item accepted
      logic             issue;    // read one tap
      logic [TAP_W-1:0] tap_idx;
      logic             finish;   // load result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [TCNT_W-1:0] taps;      // clamped tap count
      logic              pipe_busy; // MAC pipeline holds a tap
      logic              out_busy;  // result register full and stalled
   } dp_status_type;

endpackage : phr_pkg
`default_nettype wire

[rtl/core/phr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module phr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : phr_ram
`default_nettype wire

[rtl/core/phr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phr_ctrl
// Sequencer: takes items, steps the tap counter, waits for the MAC pipe to
// drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module phr_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic [phr_pkg::OPC_W-1:0]   req_opcode,
   output      logic                        req_ready,
   input  wire phr_pkg::dp_status_type      status,
   output      phr_pkg::ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_TAPS   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [phr_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic                      accept;
   logic                      start;
   logic [phr_pkg::TCNT_W-1:0] tap_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_ready;
   assign start     = accept && (req_opcode == phr_pkg::OP_COMPUTE);
   assign tap_next  = {1'b0, tap_ff} + phr_pkg::TCNT_W'(1);

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            tap_in = '0;
            if (start) begin
               state_in = (status.taps == '0) ? ST_DRAIN : ST_TAPS;
            end
         end
         ST_TAPS: begin
            tap_in = tap_ff + phr_pkg::TAP_W'(1);
            if (tap_next >= status.taps) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   assign cmd.accept  = accept;
   assign cmd.start   = start;
   assign cmd.issue   = (state_ff == ST_TAPS);
   assign cmd.tap_idx = tap_ff;
   assign cmd.finish  = (state_ff == ST_FINISH) && !status.out_busy;

   // a compute item holds off the input side until its result is loaded
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ready)
      else $error("input taken while a compute is in flight");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("no return to idle after result load");

   a_issue_fills_pipe: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> status.pipe_busy)
      else $error("tap read did not enter the MAC pipe");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.pipe_busy)
      else $error("MAC pipe busy while idle");

endmodule : phr_ctrl
`default_nettype wire

[rtl/core/phr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phr_dp
// Datapath: settings registers, the three stores, the MAC pipeline
// (read, multiply, accumulate) and the rounded, clipped result register.
// ----------------------------------------------------------------------------
module phr_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [phr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [phr_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  wire logic [phr_pkg::OPC_W-1:0]      opcode,
   input  wire logic [phr_pkg::POS_W-1:0]      position,
   input  wire logic [phr_pkg::TAP_W-1:0]      tap_index,
   input  wire logic [phr_pkg::SAMPLE_W-1:0]   sample_value,
   input  wire logic signed [phr_pkg::COEFF_W-1:0] coeff_value,
   input  wire logic [phr_pkg::POS_W-1:0]      left_value,
   input  wire phr_pkg::ctrl_cmd_type          cmd,
   output      phr_pkg::dp_status_type         status,
   input  wire logic                           rsp_tready,
   output      logic                           rsp_valid,
   output      logic [phr_pkg::SAMPLE_W-1:0]   filtered_sample,
   output      logic [phr_pkg::POS_W-1:0]      output_position,
   output      logic                           saturated
);

   // settings
   logic [phr_pkg::TCNT_W-1:0] tap_count_ff;
   logic [phr_pkg::IWID_W-1:0] row_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= phr_pkg::TAP_COUNT_RST;
         row_len_ff   <= phr_pkg::ROW_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            phr_pkg::CSR_TAP_COUNT: tap_count_ff <= csr_wdata[phr_pkg::TCNT_W-1:0];
            phr_pkg::CSR_ROW_LEN:   row_len_ff   <= csr_wdata[phr_pkg::IWID_W-1:0];
            default: ;
         endcase
      end
   end

   assign status.taps = (tap_count_ff > phr_pkg::TCNT_W'(phr_pkg::MAX_TAPS))
                      ? phr_pkg::TCNT_W'(phr_pkg::MAX_TAPS) : tap_count_ff;

   // stores
   logic [phr_pkg::POS_W-1:0]    pos_ff;
   logic [phr_pkg::POS_W-1:0]    left_rd;
   logic [phr_pkg::SAMPLE_W-1:0] line_rd;
   logic [phr_pkg::COEFF_W-1:0]  coeff_rd;
   logic [phr_pkg::IDX_W-1:0]    src_idx;
   logic                         src_in_range;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff <= position;
      end
   end

   assign src_idx      = {1'b0, left_rd} + phr_pkg::IDX_W'(cmd.tap_idx);
   assign src_in_range = !src_idx[phr_pkg::IDX_W-1]
                      && (phr_pkg::IWID_W'(src_idx) < row_len_ff);

   phr_ram #(.WIDTH(phr_pkg::SAMPLE_W), .DEPTH(phr_pkg::MAX_WIDTH)) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.accept && (opcode == phr_pkg::OP_SAMPLE)),
      .wr_addr (position),
      .wr_data (sample_value),
      .rd_en   (cmd.issue),
      .rd_addr (src_idx[phr_pkg::POS_W-1:0]),
      .rd_data (line_rd)
   );

   phr_ram #(.WIDTH(phr_pkg::COEFF_W), .DEPTH(phr_pkg::MAX_WIDTH * phr_pkg::MAX_TAPS))
   u_coeff_store (
      .clock   (clock),
      .wr_en   (cmd.accept && (opcode == phr_pkg::OP_COEFF)),
      .wr_addr ({position, tap_index}),
      .wr_data (coeff_value),
      .rd_en   (cmd.issue),
      .rd_addr ({pos_ff, cmd.tap_idx}),
      .rd_data (coeff_rd)
   );

   phr_ram #(.WIDTH(phr_pkg::POS_W), .DEPTH(phr_pkg::MAX_WIDTH)) u_left_store (
      .clock   (clock),
      .wr_en   (cmd.accept && (opcode == phr_pkg::OP_LEFT)),
      .wr_addr (position),
      .wr_data (left_value),
      .rd_en   (cmd.start),
      .rd_addr (position),
      .rd_data (left_rd)
   );

   // MAC pipeline: read -> multiply -> accumulate
   logic                              rd_vld_ff, in_range_ff, mul_vld_ff;
   logic [phr_pkg::SAMPLE_W-1:0]      sample_m;
   logic signed [phr_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic signed [phr_pkg::ACC_W-1:0]  acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff <= src_in_range;
   end

   assign sample_m = in_range_ff ? line_rd : '0;
   assign prod_in  = $signed(coeff_rd) * $signed({1'b0, sample_m});
   assign acc_in   = acc_ff + phr_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign status.pipe_busy = rd_vld_ff || mul_vld_ff;

   // round, shift, clip
   logic signed [phr_pkg::ACC_W-1:0] rounded;
   logic                             neg, over;

   assign rounded = acc_ff + phr_pkg::ACC_W'(1 << (phr_pkg::FRAC_W - 1));
   assign neg     = rounded[phr_pkg::ACC_W-1];
   assign over    = |rounded[phr_pkg::ACC_W-2:phr_pkg::FRAC_W+phr_pkg::SAMPLE_W];

   // result register
   logic                         rsp_valid_ff;
   logic [phr_pkg::SAMPLE_W-1:0] filt_ff;
   logic [phr_pkg::POS_W-1:0]    opos_ff;
   logic                         sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         opos_ff <= pos_ff;
         sat_ff  <= neg || over;
         if (neg) begin
            filt_ff <= '0;
         end else if (over) begin
            filt_ff <= '1;
         end else begin
            filt_ff <= rounded[phr_pkg::FRAC_W+phr_pkg::SAMPLE_W-1:phr_pkg::FRAC_W];
         end
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_valid       = rsp_valid_ff;
   assign filtered_sample = filt_ff;
   assign output_position = opos_ff;
   assign saturated       = sat_ff;

endmodule : phr_dp
`default_nettype wire

[rtl/core/polyphase_horizontal_resampler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_horizontal_resampler_core
// Horizontal polyphase resampler with per-output coefficients and left index.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: each transfer carries an opcode in tuser. Sample, coefficient
//    and left-index writes go to on-chip stores and give no result; the next
//    transfer may follow at once, but none is taken while a compute is in flight.
//  - A compute transfer reads the output's left index, then runs one shared
//    multiply-accumulate per tap: one store read per cycle, then a multiply
//    stage and an accumulate stage. When the pipe has drained, the result
//    loads into the output register and the input side is ready in the cycle
//    after the load (counts above 16 act as 16; tap_count zero runs no reads).
//    The single read port of the stores sets the per-tap rate.
//  - rsp channel: the rounded, clipped pixel, its output index and a
//    saturation flag sit in an output register. While it waits for the
//    receiver, new writes and one more compute run; that compute holds in its
//    final state until the register frees.
//  - csr port: tap_count (index 0) and row length (index 1), to be written
//    only while idle; the core does not enforce this. Reset restores tap_count
//    1 and row length 4096 and empties the pipeline and output register; store
//    contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module polyphase_horizontal_resampler_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req: tdata = position[11:0], tap_index[15:12], sample_value[31:16],
   //       coeff_value[47:32], left_value[59:48], zero[63:60]
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [63:0]                   req_tdata,
   // req: tuser = opcode[1:0]
   input  wire logic [phr_pkg::OPC_W-1:0]     req_tuser,
   // rsp: tdata = filtered_sample[15:0], output_position[27:16], zero[31:28]
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [31:0]                   rsp_tdata,
   // rsp: tuser = saturated[0]
   output      logic                          rsp_tuser,
   // settings write port
   input  wire logic                          csr_we,
   input  wire logic [phr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [phr_pkg::CSR_DAT_W-1:0] csr_wdata
);

   phr_pkg::ctrl_cmd_type  cmd;
   phr_pkg::dp_status_type status;

   logic [phr_pkg::SAMPLE_W-1:0] filtered_sample;
   logic [phr_pkg::POS_W-1:0]    output_position;

   phr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   phr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .opcode          (req_tuser),
      .position        (req_tdata[11:0]),
      .tap_index       (req_tdata[15:12]),
      .sample_value    (req_tdata[31:16]),
      .coeff_value     ($signed(req_tdata[47:32])),
      .left_value      (req_tdata[59:48]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .filtered_sample (filtered_sample),
      .output_position (output_position),
      .saturated       (rsp_tuser)
   );

   assign rsp_tdata = {4'b0, output_position, filtered_sample};

endmodule : polyphase_horizontal_resampler_core
`default_nettype wire
